[hw/rtl/lcg48_pkg.sv]
// ----------------------------------------------------------------------------
// lcg48_pkg
// Shared types and constants of the 48-bit linear congruential generator.
// ----------------------------------------------------------------------------
package lcg48_pkg;

  localparam logic [1:0] CMD_SEED  = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_RANGE = 2'd2;
  localparam logic [1:0] CMD_KEY   = 2'd3;

  localparam logic [47:0] LCG_RESET = 48'h1234_ABCD_330E;
  localparam logic [47:0] LCG_INC   = 48'h0000_0000_000B;
  localparam logic [15:0] SEED_LOW  = 16'h330E;

  // multiplier 0x5DEECE66D in 16-bit chunks
  localparam logic [15:0] MULT_LO  = 16'hE66D;
  localparam logic [15:0] MULT_MID = 16'hDEEC;
  localparam logic [15:0] MULT_HI  = 16'h0005;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic        [31:0] seed_word;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } req_t;

  typedef struct packed {
    logic        [62:0] number;
    logic signed [31:0] ranged;
    logic               bad_range;
  } rsp_t;

endpackage

[hw/rtl/lcg48_mul.sv]
// ----------------------------------------------------------------------------
// lcg48_mul
// Iterative state advance: one 16x16 multiplier and a 48-bit accumulator
// form (0x5DEECE66D * x + 0xB) mod 2^48.
// ----------------------------------------------------------------------------
module lcg48_mul
  import lcg48_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] state_in,
  output logic        done,
  output logic [47:0] state_out
);

  logic        busy;
  logic [2:0]  cnt;
  logic [47:0] acc;
  logic [47:0] x;
  logic [31:0] prod;
  logic [1:0]  sh;
  logic [15:0] a_sel;
  logic [15:0] m_sel;
  logic [1:0]  sh_next;
  logic [47:0] addend;

  // partial products with chunk positions summing below three
  always_comb begin
    a_sel   = x[15:0];
    m_sel   = MULT_LO;
    sh_next = 2'd0;
    case (cnt)
      3'd0: begin
        a_sel = x[15:0];  m_sel = MULT_LO;  sh_next = 2'd0;
      end
      3'd1: begin
        a_sel = x[15:0];  m_sel = MULT_MID; sh_next = 2'd1;
      end
      3'd2: begin
        a_sel = x[31:16]; m_sel = MULT_LO;  sh_next = 2'd1;
      end
      3'd3: begin
        a_sel = x[15:0];  m_sel = MULT_HI;  sh_next = 2'd2;
      end
      3'd4: begin
        a_sel = x[31:16]; m_sel = MULT_MID; sh_next = 2'd2;
      end
      3'd5: begin
        a_sel = x[47:32]; m_sel = MULT_LO;  sh_next = 2'd2;
      end
      default: begin
        a_sel = x[15:0];  m_sel = MULT_LO;  sh_next = 2'd0;
      end
    endcase
  end

  always_comb begin
    case (sh)
      2'd0:    addend = {16'h0000, prod};
      2'd1:    addend = {prod, 16'h0000};
      2'd2:    addend = {prod[15:0], 32'h0000_0000};
      default: addend = 48'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd6) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= state_in;
      acc <= LCG_INC;
    end else if (busy) begin
      prod <= a_sel * m_sel;
      sh   <= sh_next;
      if (cnt != 3'd0) begin
        acc <= acc + addend;
      end
    end
  end

  assign state_out = acc;

endmodule

[hw/rtl/lcg48_mod.sv]
// ----------------------------------------------------------------------------
// lcg48_mod
// Restoring remainder of a 31-bit draw by a 33-bit span, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module lcg48_mod
  import lcg48_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic        busy;
  logic [4:0]  cnt;
  logic [30:0] dq;
  logic [32:0] rem;
  logic [32:0] dvs;
  logic [33:0] trial;
  logic [33:0] diff;

  assign trial = {rem, dq[30]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dvs <= divisor;
      rem <= 33'd0;
    end else if (busy) begin
      dq <= {dq[29:0], 1'b0};
      if (!diff[33]) begin
        rem <= diff[32:0];
      end else begin
        rem <= trial[32:0];
      end
    end
  end

  assign remainder = rem[31:0];

endmodule

[hw/rtl/lcg48_random_generator_unit.sv]
// ----------------------------------------------------------------------------
// lcg48_random_generator_unit
// drand48-style generator: seed, 31-bit draw, ranged draw and 63-bit key.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one response per
// request. Each state advance runs on a shared 16x16 multiplier. A seed needs
// no advance, a draw one, a range one advance followed by the bit-serial
// remainder, which dominates, and a key four dependent advances. An invalid
// range leaves the state untouched. A finished response waits in an output
// register, so the next request is taken while it is still pending.
module lcg48_random_generator_unit
  import lcg48_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DRAW = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]         state;
  logic [47:0]        lcg;
  logic [1:0]         cmd;
  logic [1:0]         draw_idx;
  logic [30:0]        w_hi;
  logic [30:0]        w_lo;
  logic [32:0]        span;
  logic signed [31:0] low;
  logic signed [31:0] ranged;
  logic               bad;
  logic               mul_start;
  logic               mod_start;

  logic               mul_done;
  logic [47:0]        mul_state;
  logic               mod_done;
  logic [31:0]        mod_rem;
  logic [30:0]        draw;
  logic [1:0]         last_idx;
  logic [32:0]        span_next;
  logic               bad_next;
  rsp_t               rsp_next;

  lcg48_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .state_in  (lcg),
    .done      (mul_done),
    .state_out (mul_state)
  );

  lcg48_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (w_hi),
    .divisor   (span),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign req_ready = (state == ST_IDLE);
  assign draw      = mul_state[47:17];
  assign last_idx  = (cmd == CMD_KEY) ? 2'd3 : 2'd0;
  assign bad_next  = (req.range_high <= req.range_low);
  assign span_next = {req.range_high[31], req.range_high}
                   - {req.range_low[31], req.range_low} + 33'd1;

  always_comb begin
    rsp_next.ranged    = ranged;
    rsp_next.bad_range = bad;
    case (cmd)
      CMD_DRAW: rsp_next.number = {32'h0000_0000, w_hi};
      CMD_KEY:  rsp_next.number = {w_hi, 1'b0, w_lo};
      default:  rsp_next.number = 63'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lcg       <= LCG_RESET;
      mul_start <= 1'b0;
      mod_start <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      mod_start <= 1'b0;
      if (state == ST_FIN && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            case (req.cmd)
              CMD_SEED: begin
                lcg   <= {req.seed_word, SEED_LOW};
                state <= ST_FIN;
              end
              CMD_RANGE: begin
                if (bad_next) begin
                  state <= ST_FIN;
                end else begin
                  mul_start <= 1'b1;
                  state     <= ST_DRAW;
                end
              end
              default: begin
                mul_start <= 1'b1;
                state     <= ST_DRAW;
              end
            endcase
          end
        end
        ST_DRAW: begin
          if (mul_done) begin
            lcg <= mul_state;
            if (cmd == CMD_RANGE) begin
              mod_start <= 1'b1;
              state     <= ST_MOD;
            end else if (draw_idx == last_idx) begin
              state <= ST_FIN;
            end else begin
              mul_start <= 1'b1;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd      <= req.cmd;
      draw_idx <= 2'd0;
      w_hi     <= 31'd0;
      w_lo     <= 31'd0;
      span     <= span_next;
      low      <= req.range_low;
      ranged   <= 32'sd0;
      bad      <= (req.cmd == CMD_RANGE) && bad_next;
    end
    if (state == ST_DRAW && mul_done) begin
      draw_idx <= draw_idx + 2'd1;
      case (draw_idx)
        2'd0:    w_hi <= draw;
        2'd1:    w_hi <= {w_hi[14:0], 16'h0000} ^ draw;
        2'd2:    w_lo <= draw;
        2'd3:    w_lo <= {w_lo[14:0], 16'h0000} ^ draw;
        default: w_lo <= w_lo;
      endcase
    end
    if (state == ST_MOD && mod_done) begin
      ranged <= $signed(mod_rem + low);
    end
    if (state == ST_FIN && (!rsp_valid || rsp_ready)) begin
      rsp <= rsp_next;
    end
  end

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_range |-> rsp.number == 63'd0 && rsp.ranged == 32'sd0)
    else $error("invalid range response carries data");

  a_key_gap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !rsp.number[31])
    else $error("number bit 31 set");

endmodule

[verif/lcg48_random_generator_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcg48_random_generator_unit_test
// Self-checking bench for the 48-bit linear congruential generator unit.
// Requests are sent over a valid/ready channel, each is predicted on
// acceptance against a local model of the generator state, and every
// response is checked field by field against the oldest prediction.
// Directed cases cover the reset state, seed extremes, range limits and
// rejected ranges. A long random mix and an output stall that backs up the
// input channel follow.
// ----------------------------------------------------------------------------
module lcg48_random_generator_unit_test;
  import lcg48_pkg::*;

  localparam int RANDOM_REQS = 820;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 60;
  localparam logic [47:0] LCG_MULT = {MULT_HI, MULT_MID, MULT_LO};

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  logic [47:0] model_state;
  rsp_t        expected_rsps[$];
  int          mismatches;
  int          idle_cycles;
  int          cmd_count[4];
  int          rejected_ranges;
  bit          steady_flow;
  bit          hold_request;

  lcg48_random_generator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [30:0] advance_lcg();
    model_state = model_state * LCG_MULT + LCG_INC;
    return model_state[47:17];
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t        res;
    longint      lo;
    longint      hi;
    longint      span;
    longint      val;
    logic [30:0] d1;
    logic [30:0] d2;
    logic [30:0] d3;
    logic [30:0] d4;
    logic [63:0] hword;
    logic [63:0] lword;
    res = '0;
    case (r.cmd)
      CMD_SEED: model_state = {r.seed_word, SEED_LOW};
      CMD_DRAW: res.number = {32'b0, advance_lcg()};
      CMD_RANGE: begin
        lo = longint'(r.range_low);
        hi = longint'(r.range_high);
        if (hi <= lo) begin
          res.bad_range = 1'b1;
        end else begin
          span = hi - lo + 1;
          d1 = advance_lcg();
          val = longint'({33'b0, d1}) % span + lo;
          res.ranged = val[31:0];
        end
      end
      default: begin
        d1 = advance_lcg();
        d2 = advance_lcg();
        d3 = advance_lcg();
        d4 = advance_lcg();
        hword = ({33'b0, d1} << 16) ^ {33'b0, d2};
        lword = ({33'b0, d3} << 16) ^ {33'b0, d4};
        res.number = {hword[30:0], 1'b0, lword[30:0]};
      end
    endcase
    return res;
  endfunction

  // predict on request acceptance, check on response acceptance
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (req_valid && req_ready) begin
        cmd_count[req.cmd]++;
        if (req.cmd == CMD_RANGE && req.range_high <= req.range_low) rejected_ranges++;
        expected_rsps.push_back(predict_response(req));
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response number %h ranged %0d bad_range %b",
                   $time, rsp.number, rsp.ranged, rsp.bad_range);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.number !== want.number) begin
            mismatches++;
            $display("%0t: number expected %h actual %h", $time, want.number, rsp.number);
          end
          if (rsp.ranged !== want.ranged) begin
            mismatches++;
            $display("%0t: ranged expected %0d actual %0d", $time, want.ranged, rsp.ranged);
          end
          if (rsp.bad_range !== want.bad_range) begin
            mismatches++;
            $display("%0t: bad_range expected %b actual %b", $time, want.bad_range,
                     rsp.bad_range);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("lcg48_random_generator_unit test failed");
        $finish;
      end
    end
  end

  // response side: random stall per response, long hold-off on request
  initial begin
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        rsp_ready <= 1'b1;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 9);
        if (stall > 0) begin
          rsp_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        rsp_ready <= 1'b1;
      end
      do @(posedge clk); while (!rsp_valid);
    end
  end

  task automatic send_request(input req_t item);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  function automatic req_t make_req(logic [1:0] cmd, logic [31:0] seed_word,
                                    logic signed [31:0] lo, logic signed [31:0] hi);
    req_t r;
    r.cmd        = cmd;
    r.seed_word  = seed_word;
    r.range_low  = lo;
    r.range_high = hi;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int          pick;
    int          width;
    logic [31:0] tmp;
    r.seed_word  = $urandom;
    r.range_low  = $urandom;
    r.range_high = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 10) r.cmd = CMD_SEED;
    else if (pick < 40) r.cmd = CMD_DRAW;
    else if (pick < 75) r.cmd = CMD_RANGE;
    else r.cmd = CMD_KEY;
    pick = $urandom_range(0, 9);
    if (pick >= 2 && pick <= 5) begin
      // order the bounds so the range is usable
      if (r.range_high < r.range_low) begin
        tmp          = r.range_low;
        r.range_low  = r.range_high;
        r.range_high = tmp;
      end
    end else if (pick >= 6 && pick <= 8) begin
      width = $urandom_range(1, 1000);
      if (r.range_low > 32'sh7FFF_FFFF - width) r.range_low = 32'sh7FFF_FFFF - width;
      r.range_high = r.range_low + width;
    end else if (pick == 9) begin
      r.range_high = r.range_low;
    end
    return r;
  endfunction

  task automatic test_reset_state();
    send_request(make_req(CMD_DRAW, $urandom, $urandom, $urandom));
    send_request(make_req(CMD_RANGE, $urandom, 0, 99));
    send_request(make_req(CMD_KEY, $urandom, $urandom, $urandom));
  endtask

  task automatic test_seed_draw();
    send_request(make_req(CMD_SEED, 32'h0000_0000, 0, 0));
    send_request(make_req(CMD_DRAW, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_request(make_req(CMD_DRAW, 0, 0, 0));
    send_request(make_req(CMD_SEED, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_request(make_req(CMD_DRAW, 0, 0, 0));
    send_request(make_req(CMD_SEED, $urandom, $urandom, $urandom));
    send_request(make_req(CMD_DRAW, $urandom, $urandom, $urandom));
  endtask

  task automatic test_range_bounds();
    send_request(make_req(CMD_RANGE, 0, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_request(make_req(CMD_RANGE, 0, 32'sh8000_0000, 32'sh8000_0001));
    send_request(make_req(CMD_RANGE, 0, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF));
    send_request(make_req(CMD_RANGE, 0, 0, 0));
    send_request(make_req(CMD_RANGE, 0, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_request(make_req(CMD_RANGE, 0, 5, -5));
    // the rejected ranges must leave the state where it was
    send_request(make_req(CMD_DRAW, 0, 0, 0));
    send_request(make_req(CMD_RANGE, 0, -10, -1));
    send_request(make_req(CMD_RANGE, 0, -1, 0));
    send_request(make_req(CMD_RANGE, 0, 32'sh8000_0000, -1));
    send_request(make_req(CMD_RANGE, 0, 0, 32'sh7FFF_FFFF));
  endtask

  task automatic test_key();
    send_request(make_req(CMD_SEED, 32'h8000_0001, 0, 0));
    send_request(make_req(CMD_KEY, 0, 0, 0));
    send_request(make_req(CMD_KEY, $urandom, $urandom, $urandom));
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RANDOM_REQS; i++) begin
      steady_flow = (i % 200) >= 150;
      send_request(random_request());
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_output_stall();
    hold_request = 1'b1;
    steady_flow  = 1'b1;
    for (int i = 0; i < 12; i++) send_request(random_request());
    steady_flow = 1'b0;
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    req_valid       = 1'b0;
    req             = '0;
    rsp_ready       = 1'b0;
    model_state     = LCG_RESET;
    mismatches      = 0;
    idle_cycles     = 0;
    rejected_ranges = 0;
    steady_flow     = 1'b0;
    hold_request    = 1'b0;
    cmd_count       = '{default: 0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_seed_draw();
    test_range_bounds();
    test_key();
    test_random_mix();
    test_output_stall();
    req_valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d seeds, %0d draws, %0d ranged draws (%0d rejected), %0d keys",
             cmd_count[CMD_SEED], cmd_count[CMD_DRAW], cmd_count[CMD_RANGE],
             rejected_ranges, cmd_count[CMD_KEY]);
    $display("random idling on both sides plus a %0d-cycle response hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("lcg48_random_generator_unit test passed");
    end else begin
      $display("lcg48_random_generator_unit test failed");
    end
    $finish;
  end

endmodule
